/* design/template_to_code_translator_unit_macros.svh */
// ----------------------------------------------------------------------------
// Template to code translator assertion macros
// Immediate-consequence and next-cycle property checks shared by the design.
// ----------------------------------------------------------------------------
`ifndef TEMPLATE_TO_CODE_TRANSLATOR_UNIT_MACROS_SVH
`define TEMPLATE_TO_CODE_TRANSLATOR_UNIT_MACROS_SVH
`ifndef SYNTH
`define TTC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ttc assertion failed");
`define TTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ttc assertion failed");
`else
`define TTC_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define TTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* design/ttc_pkg.sv */
// ----------------------------------------------------------------------------
// Template to code translator package
// Command format between front and back, generated text strings and sizes.
// ----------------------------------------------------------------------------
package ttc_pkg;

    localparam int NUM_SLOTS = 10;
    localparam int SLOT_W    = 4;
    localparam int IDX_W     = 5;
    localparam int MAX_RES   = 36;
    localparam int CNT_W     = 6;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    // Output slots of one command, emitted in this order.
    localparam logic [SLOT_W-1:0] SLOT_PRE  = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_X0   = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_X1   = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_STR  = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_Y    = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_F0   = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_F1   = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_F2   = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_F3   = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_TAIL = 4'd9;

    localparam logic [7:0] CH_LT  = 8'h3C;
    localparam logic [7:0] CH_PCT = 8'h25;
    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_BS  = 8'h5C;
    localparam logic [7:0] CH_N   = 8'h6E;
    localparam logic [7:0] CH_RP  = 8'h29;

    localparam logic [0:25][7:0] TXT_PRELUDE   = "let _ = fdWriteChars(fd, \"";
    localparam logic [0:24][7:0] TXT_OPEN_EXP  = "\"); _ = fdWriteChars(fd, ";
    localparam logic [0:3][7:0]  TXT_OPEN_CODE = "\"); ";
    localparam logic [0:23][7:0] TXT_REOPEN    = "; _ = fdWriteChars(fd, \"";
    localparam logic [0:5][7:0]  TXT_TAIL      = " in ()";

    typedef enum logic [2:0] {
        STR_PRE       = 3'd0,
        STR_OPEN_EXP  = 3'd1,
        STR_OPEN_CODE = 3'd2,
        STR_REOPEN    = 3'd3,
        STR_TAIL      = 3'd4
    } t_str_id;

    typedef struct packed {
        logic                     last;
        t_str_id                  strb;
        logic [NUM_SLOTS-1:0]     mask;
        logic [NUM_SLOTS-1:0][7:0] bytes;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } t_pick;

    function automatic logic [IDX_W-1:0] str_len(input t_str_id id);
        logic [IDX_W-1:0] len;
        case (id)
            STR_PRE:       len = IDX_W'(26);
            STR_OPEN_EXP:  len = IDX_W'(25);
            STR_OPEN_CODE: len = IDX_W'(4);
            STR_REOPEN:    len = IDX_W'(24);
            STR_TAIL:      len = IDX_W'(6);
            default:       len = IDX_W'(1);
        endcase
        return len;
    endfunction

    function automatic logic [7:0] str_char(input t_str_id id, input logic [IDX_W-1:0] idx);
        logic [7:0] ch;
        case (id)
            STR_PRE:       ch = TXT_PRELUDE[idx];
            STR_OPEN_EXP:  ch = TXT_OPEN_EXP[idx];
            STR_OPEN_CODE: ch = TXT_OPEN_CODE[idx[1:0]];
            STR_REOPEN:    ch = TXT_REOPEN[idx];
            STR_TAIL:      ch = TXT_TAIL[idx];
            default:       ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* design/ttc_front.sv */
// ----------------------------------------------------------------------------
// Template to code translator front end
// Scans template bytes, tracks the delimiter state and builds output commands.
// ----------------------------------------------------------------------------
module ttc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_in_byte,
    input  logic            i_in_final,
    input  ttc_pkg::t_q_stat i_stat,
    output logic            o_ready,
    output logic            o_push,
    output ttc_pkg::t_cmd   o_cmd
);

    typedef enum logic [7:0] {
        M_LIT      = 8'b0000_0001,
        M_LIT_LT   = 8'b0000_0010,
        M_LIT_LTP  = 8'b0000_0100,
        M_LIT_RAW  = 8'b0000_1000,
        M_EXP      = 8'b0001_0000,
        M_EXP_PCT  = 8'b0010_0000,
        M_CODE     = 8'b0100_0000,
        M_CODE_PCT = 8'b1000_0000
    } t_mode;

    t_mode          r_mode, n_mode, pm;
    logic           r_pre_sent, n_pre_sent;
    ttc_pkg::t_cmd  cmd;
    logic           accept;

    always_comb begin
        cmd = '0;
        cmd.strb = ttc_pkg::STR_REOPEN;
        cmd.mask[ttc_pkg::SLOT_PRE] = !r_pre_sent;
        pm = r_mode;

        unique case (r_mode) inside
            M_LIT: begin
                if (i_in_byte == ttc_pkg::CH_LT) begin
                    pm = M_LIT_LT;
                end else if (i_in_byte == ttc_pkg::CH_DQ || i_in_byte == ttc_pkg::CH_NL) begin
                    cmd.mask[ttc_pkg::SLOT_X0] = 1'b1;
                    cmd.mask[ttc_pkg::SLOT_X1] = 1'b1;
                    cmd.bytes[ttc_pkg::SLOT_X0] = ttc_pkg::CH_BS;
                    cmd.bytes[ttc_pkg::SLOT_X1] =
                        (i_in_byte == ttc_pkg::CH_DQ) ? ttc_pkg::CH_DQ : ttc_pkg::CH_N;
                end else begin
                    cmd.mask[ttc_pkg::SLOT_X0] = 1'b1;
                    cmd.bytes[ttc_pkg::SLOT_X0] = i_in_byte;
                end
            end
            M_LIT_LT: begin
                if (i_in_byte == ttc_pkg::CH_PCT) begin
                    pm = M_LIT_LTP;
                end else begin
                    cmd.mask[ttc_pkg::SLOT_X0] = 1'b1;
                    cmd.mask[ttc_pkg::SLOT_X1] = 1'b1;
                    cmd.bytes[ttc_pkg::SLOT_X0] = ttc_pkg::CH_LT;
                    cmd.bytes[ttc_pkg::SLOT_X1] = i_in_byte;
                    pm = M_LIT_RAW;
                end
            end
            M_LIT_LTP: begin
                cmd.mask[ttc_pkg::SLOT_STR] = 1'b1;
                if (i_in_byte == ttc_pkg::CH_EQ) begin
                    cmd.strb = ttc_pkg::STR_OPEN_EXP;
                    pm = M_EXP;
                end else begin
                    cmd.strb = ttc_pkg::STR_OPEN_CODE;
                    cmd.mask[ttc_pkg::SLOT_Y] = 1'b1;
                    cmd.bytes[ttc_pkg::SLOT_Y] = i_in_byte;
                    pm = M_CODE;
                end
            end
            M_LIT_RAW: begin
                cmd.mask[ttc_pkg::SLOT_X0] = 1'b1;
                cmd.bytes[ttc_pkg::SLOT_X0] = i_in_byte;
                pm = M_LIT;
            end
            M_EXP, M_CODE: begin
                if (i_in_byte == ttc_pkg::CH_PCT) begin
                    pm = (r_mode == M_EXP) ? M_EXP_PCT : M_CODE_PCT;
                end else begin
                    cmd.mask[ttc_pkg::SLOT_X0] = 1'b1;
                    cmd.bytes[ttc_pkg::SLOT_X0] = i_in_byte;
                end
            end
            M_EXP_PCT, M_CODE_PCT: begin
                if (i_in_byte == ttc_pkg::CH_GT) begin
                    // The expression's value call needs its closing parenthesis.
                    cmd.mask[ttc_pkg::SLOT_X0] = (r_mode == M_EXP_PCT);
                    cmd.bytes[ttc_pkg::SLOT_X0] = ttc_pkg::CH_RP;
                    cmd.mask[ttc_pkg::SLOT_STR] = 1'b1;
                    cmd.strb = ttc_pkg::STR_REOPEN;
                    pm = M_LIT;
                end else begin
                    cmd.mask[ttc_pkg::SLOT_X0] = 1'b1;
                    cmd.mask[ttc_pkg::SLOT_X1] = 1'b1;
                    cmd.bytes[ttc_pkg::SLOT_X0] = ttc_pkg::CH_PCT;
                    cmd.bytes[ttc_pkg::SLOT_X1] = i_in_byte;
                    pm = (r_mode == M_EXP_PCT) ? M_EXP : M_CODE;
                end
            end
            default: begin
                pm = M_LIT;
            end
        endcase

        // Closing text on the final byte depends on the mode left by this byte.
        if (i_in_final) begin
            cmd.last = 1'b1;
            cmd.mask[ttc_pkg::SLOT_TAIL] = 1'b1;
            unique case (pm) inside
                M_LIT_LT: begin
                    cmd.mask[ttc_pkg::SLOT_F0] = 1'b1;
                    cmd.mask[ttc_pkg::SLOT_F1] = 1'b1;
                    cmd.mask[ttc_pkg::SLOT_F2] = 1'b1;
                    cmd.bytes[ttc_pkg::SLOT_F0] = ttc_pkg::CH_LT;
                    cmd.bytes[ttc_pkg::SLOT_F1] = ttc_pkg::CH_DQ;
                    cmd.bytes[ttc_pkg::SLOT_F2] = ttc_pkg::CH_RP;
                end
                M_LIT_LTP: begin
                    cmd.mask[ttc_pkg::SLOT_F0] = 1'b1;
                    cmd.mask[ttc_pkg::SLOT_F1] = 1'b1;
                    cmd.mask[ttc_pkg::SLOT_F2] = 1'b1;
                    cmd.mask[ttc_pkg::SLOT_F3] = 1'b1;
                    cmd.bytes[ttc_pkg::SLOT_F0] = ttc_pkg::CH_LT;
                    cmd.bytes[ttc_pkg::SLOT_F1] = ttc_pkg::CH_PCT;
                    cmd.bytes[ttc_pkg::SLOT_F2] = ttc_pkg::CH_DQ;
                    cmd.bytes[ttc_pkg::SLOT_F3] = ttc_pkg::CH_RP;
                end
                M_LIT, M_LIT_RAW: begin
                    cmd.mask[ttc_pkg::SLOT_F0] = 1'b1;
                    cmd.mask[ttc_pkg::SLOT_F1] = 1'b1;
                    cmd.bytes[ttc_pkg::SLOT_F0] = ttc_pkg::CH_DQ;
                    cmd.bytes[ttc_pkg::SLOT_F1] = ttc_pkg::CH_RP;
                end
                M_EXP: begin
                    cmd.mask[ttc_pkg::SLOT_F0] = 1'b1;
                    cmd.bytes[ttc_pkg::SLOT_F0] = ttc_pkg::CH_RP;
                end
                M_EXP_PCT: begin
                    cmd.mask[ttc_pkg::SLOT_F0] = 1'b1;
                    cmd.mask[ttc_pkg::SLOT_F1] = 1'b1;
                    cmd.bytes[ttc_pkg::SLOT_F0] = ttc_pkg::CH_PCT;
                    cmd.bytes[ttc_pkg::SLOT_F1] = ttc_pkg::CH_RP;
                end
                M_CODE_PCT: begin
                    cmd.mask[ttc_pkg::SLOT_F0] = 1'b1;
                    cmd.bytes[ttc_pkg::SLOT_F0] = ttc_pkg::CH_PCT;
                end
                default: begin
                end
            endcase
        end

        n_mode     = i_in_final ? M_LIT : pm;
        n_pre_sent = !i_in_final;
    end

    assign o_ready = !i_stat.full;
    assign accept  = i_valid && !i_stat.full;
    // A byte that yields no text puts nothing in the queue.
    assign o_push  = accept && (|cmd.mask);
    assign o_cmd   = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_LIT;
            r_pre_sent <= 1'b0;
        end else if (accept) begin
            r_mode     <= n_mode;
            r_pre_sent <= n_pre_sent;
        end
    end

endmodule

/* design/ttc_queue.sv */
// ----------------------------------------------------------------------------
// Template to code translator command queue
// Short first-in first-out buffer of commands between front and back.
// ----------------------------------------------------------------------------
`include "template_to_code_translator_unit_macros.svh"

module ttc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ttc_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output ttc_pkg::t_cmd    o_head,
    output ttc_pkg::t_q_stat o_stat
);

    ttc_pkg::t_cmd r_mem [ttc_pkg::Q_DEPTH];
    logic [ttc_pkg::Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [ttc_pkg::Q_CNT_W-1:0] r_count;

    assign o_head      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == ttc_pkg::Q_CNT_W'(ttc_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + ttc_pkg::Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + ttc_pkg::Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + ttc_pkg::Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - ttc_pkg::Q_CNT_W'(1);
            end
        end
    end

    `TTC_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !o_stat.full)
    `TTC_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_stat.empty)
    `TTC_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, i_push && !i_pop, !o_stat.empty)

endmodule

/* design/ttc_back.sv */
// ----------------------------------------------------------------------------
// Template to code translator back end
// Expands commands into generated text bytes, one byte per cycle while not stalled.
// ----------------------------------------------------------------------------
`include "template_to_code_translator_unit_macros.svh"

module ttc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ttc_pkg::t_cmd    i_head,
    input  ttc_pkg::t_q_stat i_stat,
    input  logic             i_ready,
    output logic             o_pop,
    output logic             o_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_text_done
);

    // Lowest set slot of a mask.
    function automatic ttc_pkg::t_pick first_set(input logic [ttc_pkg::NUM_SLOTS-1:0] m);
        ttc_pkg::t_pick p;
        p = '0;
        for (int i = ttc_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (m[i]) begin
                p.found = 1'b1;
                p.idx   = ttc_pkg::SLOT_W'(i);
            end
        end
        return p;
    endfunction

    logic                        r_busy;
    ttc_pkg::t_cmd               r_cur;
    logic [ttc_pkg::SLOT_W-1:0]  r_slot;
    logic [ttc_pkg::IDX_W-1:0]   r_idx;
    logic [ttc_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_ovalid;
    logic [7:0]                  r_obyte;
    logic                        r_olast;
    logic                        r_odone;

    ttc_pkg::t_cmd               act;
    ttc_pkg::t_pick              head_pick, later;
    logic [ttc_pkg::SLOT_W-1:0]  s;
    logic [ttc_pkg::IDX_W-1:0]   idx;
    logic [ttc_pkg::CNT_W-1:0]   cnt;
    ttc_pkg::t_str_id            sid;
    logic                        is_str, slot_end, done, fire;
    logic [7:0]                  cur_byte;

    always_comb begin
        // A new command starts straight from the queue head, with no bubble.
        act       = r_busy ? r_cur : i_head;
        head_pick = first_set(i_head.mask);
        s         = r_busy ? r_slot : head_pick.idx;
        idx       = r_busy ? r_idx : '0;
        cnt       = r_busy ? r_cnt : '0;

        is_str = (s == ttc_pkg::SLOT_PRE) || (s == ttc_pkg::SLOT_STR) ||
                 (s == ttc_pkg::SLOT_TAIL);
        if (s == ttc_pkg::SLOT_PRE) begin
            sid = ttc_pkg::STR_PRE;
        end else if (s == ttc_pkg::SLOT_TAIL) begin
            sid = ttc_pkg::STR_TAIL;
        end else begin
            sid = act.strb;
        end

        cur_byte = is_str ? ttc_pkg::str_char(sid, idx) : act.bytes[s];
        slot_end = !is_str || (idx == ttc_pkg::str_len(sid) - ttc_pkg::IDX_W'(1));
        later    = first_set(act.mask & ~((ttc_pkg::NUM_SLOTS'(2) << s) -
                                          ttc_pkg::NUM_SLOTS'(1)));
        // Text beyond the result limit of one byte is dropped.
        done     = (slot_end && !later.found) ||
                   (cnt == ttc_pkg::CNT_W'(ttc_pkg::MAX_RES - 1));
        fire     = (!r_ovalid || i_ready) && (r_busy || !i_stat.empty);
    end

    assign o_pop       = fire && !r_busy;
    assign o_valid     = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_run_last  = r_olast;
    assign o_text_done = r_odone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (fire) begin
            r_busy   <= !done;
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_obyte <= cur_byte;
            r_olast <= done;
            r_odone <= done && act.last;
            r_cur   <= act;
            r_slot  <= slot_end ? later.idx : s;
            r_idx   <= slot_end ? '0 : idx + ttc_pkg::IDX_W'(1);
            r_cnt   <= cnt + ttc_pkg::CNT_W'(1);
        end
    end

    `TTC_ASSERT_NOW(a_busy_slot_live, i_clk, i_rst_n, r_busy, r_cur.mask[r_slot])
    `TTC_ASSERT_NOW(a_busy_has_count, i_clk, i_rst_n, r_busy, r_cnt != '0)

endmodule

/* design/template_to_code_translator_unit.sv */
// ----------------------------------------------------------------------------
// Template to code translator
// Turns a server-page template byte stream into the text of a printing program.
// ----------------------------------------------------------------------------
// One template byte is accepted per cycle while the four-entry command queue
// has room; the byte is classified at once and turned into a command. The
// back end then sends out one generated byte per cycle while the receiver is
// ready; an input byte yields n bytes (1 to 36, typically 1), and the output
// rate of one byte per cycle, set by the back end's single text sequencer, is
// what bounds the sustained input rate. A byte that yields no text puts
// nothing on the output.
module template_to_code_translator_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_final,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_text_done
);

    logic             push, pop;
    ttc_pkg::t_cmd    cmd, head;
    ttc_pkg::t_q_stat stat;

    ttc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_in_byte  (i_in_byte),
        .i_in_final (i_in_final),
        .i_stat     (stat),
        .o_ready    (o_ready),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    ttc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (stat)
    );

    ttc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_stat      (stat),
        .i_ready     (i_ready),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_text_done (o_text_done)
    );

endmodule

/* test/template_to_code_translator_unit_tb.sv */
// ----------------------------------------------------------------------------
// Template to code translator testbench
// Feeds server-page templates byte by byte and checks every generated code byte
// and its flags against a scoreboard fed by a behavioral translator.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module template_to_code_translator_unit_tb;

    localparam string PRELUDE_TXT   = "let _ = fdWriteChars(fd, \"";
    localparam string OPEN_EXPR_TXT = "\"); _ = fdWriteChars(fd, ";
    localparam string OPEN_CODE_TXT = "\"); ";
    localparam string REOPEN_TXT    = "; _ = fdWriteChars(fd, \"";
    localparam string TAIL_TXT      = " in ()";

    localparam int RAND_ITEMS_PER_PHASE = 90;
    localparam int HOLD_OFF_CYCLES      = 400;
    localparam int DRAIN_CYCLES         = 60;

    typedef enum logic [7:0] {
        MODE_TEXT       = 8'b0000_0001,
        MODE_TEXT_LT    = 8'b0000_0010,
        MODE_TEXT_LTPCT = 8'b0000_0100,
        MODE_TEXT_RAW   = 8'b0000_1000,
        MODE_EXPR       = 8'b0001_0000,
        MODE_EXPR_PCT   = 8'b0010_0000,
        MODE_CODE       = 8'b0100_0000,
        MODE_CODE_PCT   = 8'b1000_0000
    } t_scan_mode;

    typedef struct {
        logic [7:0] data;
        logic       is_last;
    } t_tmpl_req;

    typedef struct {
        logic [7:0] data;
        logic       run_last;
        logic       text_done;
    } t_code_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_final = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_text_done;

    t_tmpl_req  pending_bytes[$];
    t_code_byte expected_code[$];
    t_code_byte gen_bytes[$];
    t_tmpl_req  next_req;
    t_code_byte got_code;

    t_scan_mode tmpl_mode = MODE_TEXT;
    logic       prelude_done = 1'b0;
    logic       req_taken = 1'b0;
    logic       hold_off = 1'b0;
    int         send_idle_pct = 35;
    int         recv_idle_pct = 66;
    int         test_phase = 0;
    int         err_cnt = 0;

    template_to_code_translator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_byte   (i_in_byte),
        .i_in_final  (i_in_final),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_text_done (o_text_done)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Behavioral translator
    // ------------------------------------------------------------------
    task automatic emit_char(input logic [7:0] c);
        if (gen_bytes.size() < ttc_pkg::MAX_RES) begin
            gen_bytes.push_back('{data: c, run_last: 1'b0, text_done: 1'b0});
        end
    endtask

    task automatic emit_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            emit_char(s[k]);
        end
    endtask

    task automatic scan_byte(input logic [7:0] b);
        case (tmpl_mode) inside
            MODE_TEXT: begin
                if (b == ttc_pkg::CH_LT) begin
                    tmpl_mode = MODE_TEXT_LT;
                end else if (b == ttc_pkg::CH_DQ) begin
                    emit_char(ttc_pkg::CH_BS);
                    emit_char(ttc_pkg::CH_DQ);
                end else if (b == ttc_pkg::CH_NL) begin
                    emit_char(ttc_pkg::CH_BS);
                    emit_char(ttc_pkg::CH_N);
                end else begin
                    emit_char(b);
                end
            end
            MODE_TEXT_LT: begin
                if (b == ttc_pkg::CH_PCT) begin
                    tmpl_mode = MODE_TEXT_LTPCT;
                end else begin
                    emit_char(ttc_pkg::CH_LT);
                    emit_char(b);
                    tmpl_mode = MODE_TEXT_RAW;
                end
            end
            MODE_TEXT_LTPCT: begin
                if (b == ttc_pkg::CH_EQ) begin
                    emit_text(OPEN_EXPR_TXT);
                    tmpl_mode = MODE_EXPR;
                end else begin
                    emit_text(OPEN_CODE_TXT);
                    emit_char(b);
                    tmpl_mode = MODE_CODE;
                end
            end
            MODE_TEXT_RAW: begin
                emit_char(b);
                tmpl_mode = MODE_TEXT;
            end
            MODE_EXPR, MODE_CODE: begin
                if (b == ttc_pkg::CH_PCT) begin
                    tmpl_mode = (tmpl_mode == MODE_EXPR) ? MODE_EXPR_PCT : MODE_CODE_PCT;
                end else begin
                    emit_char(b);
                end
            end
            default: begin
                if (b == ttc_pkg::CH_GT) begin
                    if (tmpl_mode == MODE_EXPR_PCT) begin
                        emit_char(ttc_pkg::CH_RP);
                    end
                    emit_text(REOPEN_TXT);
                    tmpl_mode = MODE_TEXT;
                end else begin
                    emit_char(ttc_pkg::CH_PCT);
                    emit_char(b);
                    tmpl_mode = (tmpl_mode == MODE_EXPR_PCT) ? MODE_EXPR : MODE_CODE;
                end
            end
        endcase
    endtask

    // Closes the generated text at the end of the template; a half-seen delimiter there is flushed as text.
    task automatic close_template();
        case (tmpl_mode) inside
            MODE_TEXT_LT: begin
                emit_char(ttc_pkg::CH_LT);
                emit_char(ttc_pkg::CH_DQ);
                emit_char(ttc_pkg::CH_RP);
            end
            MODE_TEXT_LTPCT: begin
                emit_char(ttc_pkg::CH_LT);
                emit_char(ttc_pkg::CH_PCT);
                emit_char(ttc_pkg::CH_DQ);
                emit_char(ttc_pkg::CH_RP);
            end
            MODE_TEXT, MODE_TEXT_RAW: begin
                emit_char(ttc_pkg::CH_DQ);
                emit_char(ttc_pkg::CH_RP);
            end
            MODE_EXPR: emit_char(ttc_pkg::CH_RP);
            MODE_EXPR_PCT: begin
                emit_char(ttc_pkg::CH_PCT);
                emit_char(ttc_pkg::CH_RP);
            end
            MODE_CODE_PCT: emit_char(ttc_pkg::CH_PCT);
            default: ;
        endcase
        emit_text(TAIL_TXT);
        tmpl_mode = MODE_TEXT;
        prelude_done = 1'b0;
    endtask

    task automatic predict_code_bytes(input logic [7:0] b, input logic is_last);
        gen_bytes.delete();
        if (!prelude_done) begin
            emit_text(PRELUDE_TXT);
            prelude_done = 1'b1;
        end
        scan_byte(b);
        if (is_last) begin
            close_template();
        end
        if (gen_bytes.size() > 0) begin
            gen_bytes[gen_bytes.size() - 1].run_last = 1'b1;
            gen_bytes[gen_bytes.size() - 1].text_done = is_last;
        end
        foreach (gen_bytes[k]) begin
            expected_code.push_back(gen_bytes[k]);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver, receiver and monitor
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || req_taken)) begin
            if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_req = pending_bytes.pop_front();
                i_valid <= 1'b1;
                i_in_byte <= next_req.data;
                i_in_final <= next_req.is_last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Prediction runs before the output check, so an expectation is queued before
    // any result that could match it is checked.
    always @(posedge i_clk) begin
        req_taken = i_rst_n && i_valid && o_ready;
        if (req_taken) begin
            predict_code_bytes(i_in_byte, i_in_final);
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_code.size() == 0) begin
                $error("unexpected output byte %0h", o_out_byte);
                err_cnt++;
            end else begin
                got_code = expected_code.pop_front();
                if (o_out_byte !== got_code.data) begin
                    $error("out_byte: expected %0h, got %0h", got_code.data, o_out_byte);
                    err_cnt++;
                end
                if (o_run_last !== got_code.run_last) begin
                    $error("run_last: expected %0b, got %0b", got_code.run_last, o_run_last);
                    err_cnt++;
                end
                if (o_text_done !== got_code.text_done) begin
                    $error("text_done: expected %0b, got %0b",
                           got_code.text_done, o_text_done);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_bytes(input logic [7:0] tq[$]);
        foreach (tq[k]) begin
            pending_bytes.push_back('{data: tq[k], is_last: (k == tq.size() - 1)});
        end
    endtask

    task automatic queue_text(input string s);
        logic [7:0] tq[$];
        for (int k = 0; k < s.len(); k++) begin
            tq.push_back(s[k]);
        end
        queue_bytes(tq);
    endtask

    // Text bytes are biased toward the characters that the translator treats
    // specially.
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0: b = ttc_pkg::CH_DQ;
            1: b = ttc_pkg::CH_NL;
            2: b = ttc_pkg::CH_LT;
            3: b = ttc_pkg::CH_PCT;
            4: b = ttc_pkg::CH_GT;
            5: b = ttc_pkg::CH_EQ;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    task automatic add_region_body(ref logic [7:0] tq[$]);
        repeat ($urandom_range(0, 4)) begin
            tq.push_back(pick_byte());
        end
        if ($urandom_range(0, 3) == 0) begin
            tq.push_back(ttc_pkg::CH_PCT);
            tq.push_back(8'($urandom_range(0, 255)));
        end
        tq.push_back(ttc_pkg::CH_PCT);
        tq.push_back(ttc_pkg::CH_GT);
    endtask

    task automatic queue_random_template(output int n);
        logic [7:0] tq[$];
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9)) inside
                0, 1, 2: begin
                    repeat ($urandom_range(1, 5)) begin
                        tq.push_back(pick_byte());
                    end
                end
                3, 4: begin
                    tq.push_back(ttc_pkg::CH_LT);
                    tq.push_back(ttc_pkg::CH_PCT);
                    tq.push_back(ttc_pkg::CH_EQ);
                    add_region_body(tq);
                end
                5, 6: begin
                    tq.push_back(ttc_pkg::CH_LT);
                    tq.push_back(ttc_pkg::CH_PCT);
                    add_region_body(tq);
                end
                7: begin
                    tq.push_back(ttc_pkg::CH_LT);
                    tq.push_back(8'($urandom_range(0, 255)));
                end
                8: begin
                    tq.push_back(ttc_pkg::CH_LT);
                    tq.push_back(ttc_pkg::CH_PCT);
                end
                default: tq.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        queue_bytes(tq);
        n = tq.size();
    endtask

    task automatic wait_all_accepted();
        while (pending_bytes.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int sent;
        int n;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_text("\"");
        queue_text("<%=%q%>");
        queue_text("<a\"");
        queue_text("<%");
        queue_text("<");
        queue_text("<%k%");
        queue_text("<%=v%");
        queue_bytes('{ttc_pkg::CH_NL, 8'hFF, 8'h00});

        for (int p = 0; p < 3; p++) begin
            test_phase = p;
            case (p)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 66;
                end
                1: begin
                    send_idle_pct = 66;
                    recv_idle_pct = 35;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < RAND_ITEMS_PER_PHASE) begin
                queue_random_template(n);
                sent += n;
            end
            wait_all_accepted();
        end

        while (expected_code.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Stall the output for a long stretch while requests keep coming, so the
    // command queue fills and the input side backs up.
    initial begin
        wait (test_phase == 2);
        repeat (20) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/ttc_pkg.sv
design/ttc_front.sv
design/ttc_queue.sv
design/ttc_back.sv
design/template_to_code_translator_unit.sv
test/template_to_code_translator_unit_tb.sv
